/* hw/rtl/epm_pkg.sv */
// epm_pkg: shared constants, types and arithmetic helpers for the euler pose block
// depends on nothing; imported by every module in hw/rtl
package epm_pkg;

	// cordic length, at most 24
	localparam int CORDIC_STEPS = 16;

	// fixed-point angle constants in Q.30
	localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [32:0] Q30_GAIN    = 33'sd652032874;

	// Q16.16 one and row codes
	localparam logic [31:0] Q16_ONE  = 32'h0001_0000;
	localparam logic [1:0]  ROW_FIRST = 2'd0;
	localparam logic [1:0]  ROW_LAST  = 2'd3;

	// rotation matrix and translation of one item
	typedef struct packed {
		logic [2:0][2:0][31:0] m;
		logic [31:0]           tx;
		logic [31:0]           ty;
		logic [31:0]           tz;
	} pose_mat_t;

	// arctangent of 2^-i in Q.30, truncated
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// round a Q.60 product back to Q.30
	function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd536870912) >>> 30;
		return t[31:0];
	endfunction

	// round a Q.30 value to Q16.16
	function automatic logic [31:0] to_q16(input logic signed [32:0] v);
		logic signed [32:0] t;
		t = (v + 33'sd8192) >>> 14;
		return t[31:0];
	endfunction

endpackage

/* hw/rtl/epm_sincos.sv */
// epm_sincos: range reduction and pipelined cordic giving sine and cosine of one angle
// depends on epm_pkg
module epm_sincos import epm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [15:0] angle,
	output logic               out_valid,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	logic signed [34:0] z_in;
	logic signed [34:0] zw_s1;
	logic               v_s1;
	logic signed [32:0] zr_s2;
	logic               neg_s2;
	logic               v_s2;

	logic signed [32:0] x_s3 [CORDIC_STEPS+1];
	logic signed [32:0] y_s3 [CORDIC_STEPS+1];
	logic signed [32:0] z_s3 [CORDIC_STEPS+1];
	logic               neg_s3 [CORDIC_STEPS+1];
	logic               v_s3 [CORDIC_STEPS+1];

	logic signed [31:0] sin_s4;
	logic signed [31:0] cos_s4;
	logic               v_s4;

	// scale Q4.12 to Q.30
	assign z_in = {{1{angle[15]}}, angle, 18'b0};

	// wrap into (-pi, pi]
	always_ff @(posedge clk) begin
		if (z_in > Q30_PI) begin
			zw_s1 <= z_in - Q30_TWO_PI;
		end else if (z_in <= -Q30_PI) begin
			zw_s1 <= z_in + Q30_TWO_PI;
		end else begin
			zw_s1 <= z_in;
		end
	end

	// fold into [-pi/2, pi/2], remember the sign flip
	always_ff @(posedge clk) begin
		if (zw_s1 > Q30_HALF_PI) begin
			zr_s2  <= 33'(zw_s1 - Q30_PI);
			neg_s2 <= 1'b1;
		end else if (zw_s1 < -Q30_HALF_PI) begin
			zr_s2  <= 33'(zw_s1 + Q30_PI);
			neg_s2 <= 1'b1;
		end else begin
			zr_s2  <= zw_s1[32:0];
			neg_s2 <= 1'b0;
		end
	end

	// cordic seed
	assign x_s3[0]   = Q30_GAIN;
	assign y_s3[0]   = '0;
	assign z_s3[0]   = zr_s2;
	assign neg_s3[0] = neg_s2;
	assign v_s3[0]   = v_s2;

	// one rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [32:0] ATAN = {1'b0, atan_q30(5'(i))};
		always_ff @(posedge clk) begin
			if (!z_s3[i][32]) begin
				x_s3[i+1] <= x_s3[i] - (y_s3[i] >>> i);
				y_s3[i+1] <= y_s3[i] + (x_s3[i] >>> i);
				z_s3[i+1] <= z_s3[i] - ATAN;
			end else begin
				x_s3[i+1] <= x_s3[i] + (y_s3[i] >>> i);
				y_s3[i+1] <= y_s3[i] - (x_s3[i] >>> i);
				z_s3[i+1] <= z_s3[i] + ATAN;
			end
			neg_s3[i+1] <= neg_s3[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[i+1] <= 1'b0;
			end else begin
				v_s3[i+1] <= v_s3[i];
			end
		end
	end

	// apply the sign flip from folding
	always_ff @(posedge clk) begin
		if (neg_s3[CORDIC_STEPS]) begin
			sin_s4 <= 32'(-y_s3[CORDIC_STEPS]);
			cos_s4 <= 32'(-x_s3[CORDIC_STEPS]);
		end else begin
			sin_s4 <= y_s3[CORDIC_STEPS][31:0];
			cos_s4 <= x_s3[CORDIC_STEPS][31:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s4 <= v_s3[CORDIC_STEPS];
		end
	end

	assign out_valid = v_s4;
	assign sin_val   = sin_s4;
	assign cos_val   = cos_s4;

endmodule

/* hw/rtl/epm_compose.sv */
// epm_compose: three-stage multiply and sum forming Rz*Ry*Rx from sines and cosines
// depends on epm_pkg
module epm_compose import epm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [31:0] sr,
	input  logic signed [31:0] cr,
	input  logic signed [31:0] sp,
	input  logic signed [31:0] cp,
	input  logic signed [31:0] sy,
	input  logic signed [31:0] cy,
	input  logic [31:0]        tx,
	input  logic [31:0]        ty,
	input  logic [31:0]        tz,
	output logic               out_valid,
	output pose_mat_t          mat
);

	logic signed [31:0] cycp_s1, cysp_s1, sycp_s1, sysp_s1, sycr_s1, sysr_s1;
	logic signed [31:0] cycr_s1, cysr_s1, cpsr_s1, cpcr_s1;
	logic signed [31:0] sr_s1, cr_s1, sp_s1;
	logic [31:0]        tx_s1, ty_s1, tz_s1;
	logic               v_s1;

	logic signed [31:0] a01_s2, a02_s2, a11_s2, a12_s2;
	logic signed [31:0] cycp_s2, sycp_s2, sycr_s2, sysr_s2, cycr_s2, cysr_s2;
	logic signed [31:0] cpsr_s2, cpcr_s2, sp_s2;
	logic [31:0]        tx_s2, ty_s2, tz_s2;
	logic               v_s2;

	pose_mat_t          mat_s3;
	logic               v_s3;

	// two-factor products
	always_ff @(posedge clk) begin
		cycp_s1 <= rnd30(64'(cy) * 64'(cp));
		cysp_s1 <= rnd30(64'(cy) * 64'(sp));
		sycp_s1 <= rnd30(64'(sy) * 64'(cp));
		sysp_s1 <= rnd30(64'(sy) * 64'(sp));
		sycr_s1 <= rnd30(64'(sy) * 64'(cr));
		sysr_s1 <= rnd30(64'(sy) * 64'(sr));
		cycr_s1 <= rnd30(64'(cy) * 64'(cr));
		cysr_s1 <= rnd30(64'(cy) * 64'(sr));
		cpsr_s1 <= rnd30(64'(cp) * 64'(sr));
		cpcr_s1 <= rnd30(64'(cp) * 64'(cr));
		sr_s1   <= sr;
		cr_s1   <= cr;
		sp_s1   <= sp;
		tx_s1   <= tx;
		ty_s1   <= ty;
		tz_s1   <= tz;
	end

	// third factor of the three-factor terms
	always_ff @(posedge clk) begin
		a01_s2  <= rnd30(64'(cysp_s1) * 64'(sr_s1));
		a02_s2  <= rnd30(64'(cysp_s1) * 64'(cr_s1));
		a11_s2  <= rnd30(64'(sysp_s1) * 64'(sr_s1));
		a12_s2  <= rnd30(64'(sysp_s1) * 64'(cr_s1));
		cycp_s2 <= cycp_s1;
		sycp_s2 <= sycp_s1;
		sycr_s2 <= sycr_s1;
		sysr_s2 <= sysr_s1;
		cycr_s2 <= cycr_s1;
		cysr_s2 <= cysr_s1;
		cpsr_s2 <= cpsr_s1;
		cpcr_s2 <= cpcr_s1;
		sp_s2   <= sp_s1;
		tx_s2   <= tx_s1;
		ty_s2   <= ty_s1;
		tz_s2   <= tz_s1;
	end

	// sums and rounding to Q16.16
	always_ff @(posedge clk) begin
		mat_s3.m[0][0] <= to_q16(33'(cycp_s2));
		mat_s3.m[0][1] <= to_q16(33'(a01_s2) - 33'(sycr_s2));
		mat_s3.m[0][2] <= to_q16(33'(a02_s2) + 33'(sysr_s2));
		mat_s3.m[1][0] <= to_q16(33'(sycp_s2));
		mat_s3.m[1][1] <= to_q16(33'(a11_s2) + 33'(cycr_s2));
		mat_s3.m[1][2] <= to_q16(33'(a12_s2) - 33'(cysr_s2));
		mat_s3.m[2][0] <= to_q16(-33'(sp_s2));
		mat_s3.m[2][1] <= to_q16(33'(cpsr_s2));
		mat_s3.m[2][2] <= to_q16(33'(cpcr_s2));
		mat_s3.tx      <= tx_s2;
		mat_s3.ty      <= ty_s2;
		mat_s3.tz      <= tz_s2;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;
	assign mat       = mat_s3;

endmodule

/* hw/rtl/epm_rows.sv */
// epm_rows: holds one finished matrix and sends it out one row per cycle
// depends on epm_pkg
module epm_rows import epm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  pose_mat_t   mat,
	output logic        done,
	output logic [1:0]  row_number,
	output logic [31:0] col0_value,
	output logic [31:0] col1_value,
	output logic [31:0] col2_value,
	output logic [31:0] col3_value,
	output logic        last_row
);

	pose_mat_t   mat_q;
	logic [1:0]  row_q;
	logic        done_q;
	logic        last_q;
	logic [1:0]  next_row;
	logic [31:0] c0_q, c1_q, c2_q, c3_q;

	assign next_row = row_q + 2'd1;

	// row sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			row_q  <= ROW_FIRST;
			last_q <= 1'b0;
		end else if (in_valid) begin
			done_q <= 1'b1;
			row_q  <= ROW_FIRST;
			last_q <= 1'b0;
		end else if (done_q && row_q != ROW_LAST) begin
			done_q <= 1'b1;
			row_q  <= next_row;
			last_q <= (next_row == ROW_LAST);
		end else begin
			done_q <= 1'b0;
			last_q <= 1'b0;
		end
	end

	// row payload
	always_ff @(posedge clk) begin
		if (in_valid) begin
			mat_q <= mat;
			c0_q  <= mat.m[0][0];
			c1_q  <= mat.m[0][1];
			c2_q  <= mat.m[0][2];
			c3_q  <= '0;
		end else begin
			unique case (next_row)
				2'd1: begin
					c0_q <= mat_q.m[1][0];
					c1_q <= mat_q.m[1][1];
					c2_q <= mat_q.m[1][2];
					c3_q <= '0;
				end
				2'd2: begin
					c0_q <= mat_q.m[2][0];
					c1_q <= mat_q.m[2][1];
					c2_q <= mat_q.m[2][2];
					c3_q <= '0;
				end
				2'd3: begin
					c0_q <= mat_q.tx;
					c1_q <= mat_q.ty;
					c2_q <= mat_q.tz;
					c3_q <= Q16_ONE;
				end
				default: begin
					c0_q <= c0_q;
					c1_q <= c1_q;
					c2_q <= c2_q;
					c3_q <= c3_q;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign row_number = row_q;
	assign col0_value = c0_q;
	assign col1_value = c1_q;
	assign col2_value = c2_q;
	assign col3_value = c3_q;
	assign last_row   = last_q;

endmodule

/* hw/rtl/euler_pose_to_matrix.sv */
// euler_pose_to_matrix: top level, z-y-x euler pose to 4x4 homogeneous transform
// depends on epm_pkg, epm_sincos, epm_compose, epm_rows
//
// usage:
//   an item (three Q4.12 angles and a Q16.16 translation) is taken at a clock
//   edge with start high and busy low. busy then stays high while gap_q counts
//   down, so the next item waits; the row output sets that spacing.
//   each item gives four rows, row 0 first, on consecutive cycles, each marked
//   by done for one cycle; last_row marks row 3 (translation and 1.0).
//   row 0 follows the accepting edge through 2 reduction stages, one cordic
//   stage per step, one sign stage, three multiply/sum stages and one row
//   register, in that order.
//   the three angles run through three parallel cordic pipelines.
//   the receiver cannot hold rows off; nothing in the block waits on it.
//   reset clears all valid bits and the row sequencer; items in flight are
//   dropped and no row is shown until a new item is taken.
module euler_pose_to_matrix import epm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	output logic               done,
	output logic [1:0]         row_number,
	output logic signed [31:0] col0_value,
	output logic signed [31:0] col1_value,
	output logic signed [31:0] col2_value,
	output logic signed [31:0] col3_value,
	output logic               last_row
);

	localparam int TR_DEPTH = CORDIC_STEPS + 3;

	logic               accept;
	logic [1:0]         gap_q;
	logic               v_roll, v_pitch, v_yaw;
	logic signed [31:0] sr, cr, sp, cp, sy, cy;
	logic [31:0]        tx_s1 [TR_DEPTH];
	logic [31:0]        ty_s1 [TR_DEPTH];
	logic [31:0]        tz_s1 [TR_DEPTH];
	logic               mat_valid;
	pose_mat_t          mat;

	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	// spacing of accepted items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// translation delay line alongside the cordic pipelines
	always_ff @(posedge clk) begin
		tx_s1[0] <= shift_x;
		ty_s1[0] <= shift_y;
		tz_s1[0] <= shift_z;
		for (int k = 1; k < TR_DEPTH; k++) begin
			tx_s1[k] <= tx_s1[k-1];
			ty_s1[k] <= ty_s1[k-1];
			tz_s1[k] <= tz_s1[k-1];
		end
	end

	// sine and cosine of each angle
	epm_sincos u_roll (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(roll_angle),
		.out_valid(v_roll), .sin_val(sr), .cos_val(cr)
	);
	epm_sincos u_pitch (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(pitch_angle),
		.out_valid(v_pitch), .sin_val(sp), .cos_val(cp)
	);
	epm_sincos u_yaw (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .angle(yaw_angle),
		.out_valid(v_yaw), .sin_val(sy), .cos_val(cy)
	);

	// matrix products
	epm_compose u_compose (
		.clk(clk), .arst_n(arst_n), .in_valid(v_roll && v_pitch && v_yaw),
		.sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
		.tx(tx_s1[TR_DEPTH-1]), .ty(ty_s1[TR_DEPTH-1]), .tz(tz_s1[TR_DEPTH-1]),
		.out_valid(mat_valid), .mat(mat)
	);

	// row output
	epm_rows u_rows (
		.clk(clk), .arst_n(arst_n), .in_valid(mat_valid), .mat(mat),
		.done(done), .row_number(row_number),
		.col0_value(col0_value), .col1_value(col1_value),
		.col2_value(col2_value), .col3_value(col3_value),
		.last_row(last_row)
	);

	// an accepted item blocks the next one for the whole spacing window
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 busy ##1 busy)
		else $error("item accepted inside the spacing window");

	// rows of one item come out in order without gaps
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		done && row_number != ROW_LAST |=> done && row_number == $past(row_number) + 2'd1)
		else $error("row sequence broken");

	// last_row marks row 3 exactly
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_row == (done && row_number == ROW_LAST))
		else $error("last_row out of step with row_number");

	// the three angle pipelines stay aligned
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		v_roll == v_pitch && v_pitch == v_yaw)
		else $error("angle pipelines out of step");

endmodule

/* tb/euler_pose_to_matrix_chk.sv */
// euler_pose_to_matrix_chk: predicts the four transform rows of each accepted pose
// and compares them with the rows the block shows; depends on epm_pkg
`timescale 1ns / 1ps

module euler_pose_to_matrix_chk import epm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  logic               done,
	input  logic [1:0]         row_number,
	input  logic signed [31:0] col0_value,
	input  logic signed [31:0] col1_value,
	input  logic signed [31:0] col2_value,
	input  logic signed [31:0] col3_value,
	input  logic               last_row,
	output int                 fail_count,
	output int                 rows_pending
);

	typedef struct packed {
		logic [1:0]  row;
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] c3;
		logic        last;
	} mat_row_t;

	mat_row_t expected_rows[$];

	// arctangent of 2^-i in Q.30, truncated
	localparam logic [31:0] ATAN_TBL [24] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	assign rows_pending = expected_rows.size();

	// sine and cosine in Q.30 of a Q4.12 angle
	task automatic angle_sin_cos(input logic signed [15:0] ang,
			output longint s, output longint c);
		longint z, x, y, t;
		bit flip;
		z = longint'(ang) * 262144;
		x = 652032874;
		y = 0;
		flip = 0;
		while (z > 64'sd3373259426) z -= 64'sd6746518852;
		while (z <= -64'sd3373259426) z += 64'sd6746518852;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TBL[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TBL[i]);
			end
			x = t;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic longint qmul(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic [31:0] q16_of(input longint v);
		longint t;
		t = (v + 8192) >>> 14;
		return t[31:0];
	endfunction

	// z-y-x rotation plus translation row
	task automatic predict_pose();
		longint sr, cr, sp, cp, sy, cy;
		longint m[3][3];
		mat_row_t r;
		angle_sin_cos(roll_angle, sr, cr);
		angle_sin_cos(pitch_angle, sp, cp);
		angle_sin_cos(yaw_angle, sy, cy);
		m[0][0] = qmul(cy, cp);
		m[0][1] = qmul(qmul(cy, sp), sr) - qmul(sy, cr);
		m[0][2] = qmul(qmul(cy, sp), cr) + qmul(sy, sr);
		m[1][0] = qmul(sy, cp);
		m[1][1] = qmul(qmul(sy, sp), sr) + qmul(cy, cr);
		m[1][2] = qmul(qmul(sy, sp), cr) - qmul(cy, sr);
		m[2][0] = -sp;
		m[2][1] = qmul(cp, sr);
		m[2][2] = qmul(cp, cr);
		for (int k = 0; k < 3; k++) begin
			r.row = 2'(k);
			r.c0 = q16_of(m[k][0]);
			r.c1 = q16_of(m[k][1]);
			r.c2 = q16_of(m[k][2]);
			r.c3 = '0;
			r.last = 1'b0;
			expected_rows.push_back(r);
		end
		r.row = ROW_LAST;
		r.c0 = shift_x;
		r.c1 = shift_y;
		r.c2 = shift_z;
		r.c3 = Q16_ONE;
		r.last = 1'b1;
		expected_rows.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %0t: %s got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// compare one shown row with the oldest expected one
	task automatic check_row();
		mat_row_t w;
		if (expected_rows.size() == 0) begin
			report_mismatch("unexpected row", 32'(row_number), '0);
			return;
		end
		w = expected_rows.pop_front();
		if (row_number !== w.row) report_mismatch("row_number", 32'(row_number), 32'(w.row));
		if (col0_value !== w.c0) report_mismatch("col0_value", col0_value, w.c0);
		if (col1_value !== w.c1) report_mismatch("col1_value", col1_value, w.c1);
		if (col2_value !== w.c2) report_mismatch("col2_value", col2_value, w.c2);
		if (col3_value !== w.c3) report_mismatch("col3_value", col3_value, w.c3);
		if (last_row !== w.last) report_mismatch("last_row", 32'(last_row), 32'(w.last));
	endtask

	initial fail_count = 0;

	// watch both channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) check_row();
			if (start && !busy) predict_pose();
		end
	end

endmodule

/* tb/euler_pose_to_matrix_tb.sv */
// euler_pose_to_matrix_tb: drives poses into euler_pose_to_matrix and gives the verdict
// depends on epm_pkg, euler_pose_to_matrix and euler_pose_to_matrix_chk
`timescale 1ns / 1ps

module euler_pose_to_matrix_tb;
	import epm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = CORDIC_STEPS + 20;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
	logic signed [31:0] shift_x, shift_y, shift_z;
	logic               done;
	logic [1:0]         row_number;
	logic signed [31:0] col0_value, col1_value, col2_value, col3_value;
	logic               last_row;
	int                 fail_count;
	int                 rows_pending;
	int                 idle_cycles;
	bit                 calm;

	euler_pose_to_matrix u_top (.*);

	euler_pose_to_matrix_chk u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles with nothing accepted and no row shown
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// offer one pose and hold it until taken, with random gaps first unless calm is set
	task automatic send_pose(input logic [15:0] r, input logic [15:0] p, input logic [15:0] y,
			input logic [31:0] x, input logic [31:0] ty, input logic [31:0] z);
		while (!calm && $urandom_range(99) < 14) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		roll_angle <= r;
		pitch_angle <= p;
		yaw_angle <= y;
		shift_x <= x;
		shift_y <= ty;
		shift_z <= z;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [15:0] pick_angle();
		unique case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(12868)) - 6434);
			2: return 16'($signed($urandom_range(200)) - 100 + 6434);
			default: return 16'($signed($urandom_range(200)) - 100 - 12868);
		endcase
	endfunction

	initial begin
		logic [15:0] edge_angles [10] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
			16'd6434, -16'sd6434, 16'd12868, -16'sd12868, 16'd3217};
		idle_cycles = 0;
		calm = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{roll_angle, pitch_angle, yaw_angle} = '0;
		{shift_x, shift_y, shift_z} = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: angle extremes on each axis, quadrant edges, translation extremes
		for (int i = 0; i < 10; i++)
			send_pose(edge_angles[i], edge_angles[(i + 3) % 10], edge_angles[(i + 7) % 10],
				(i & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF, i[0] ? 32'hFFFF_FFFF : 32'h0,
				32'h0001_0000 << i);
		send_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_pose(16'h8000, 16'h8000, 16'h8000, 32'h0, 32'h0, 32'h0);

		// sender holds off until every row is back
		start <= 1'b0;
		while (rows_pending != 0) @(posedge clk);

		// random poses, with a stretch of back-to-back offers
		for (int n = 0; n < 360; n++) begin
			calm = (n >= 150 && n < 210);
			send_pose(pick_angle(), pick_angle(), pick_angle(),
				$urandom_range(3) == 0 ? 32'h0 : $urandom, $urandom, $urandom);
		end
		calm = 0;
		start <= 1'b0;

		while (rows_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && rows_pending == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/epm_pkg.sv
hw/rtl/epm_sincos.sv
hw/rtl/epm_compose.sv
hw/rtl/epm_rows.sv
hw/rtl/euler_pose_to_matrix.sv
tb/euler_pose_to_matrix_chk.sv
tb/euler_pose_to_matrix_tb.sv
